[design/rjp_pkg.sv]
// Shared types and constants for the RTP/JPEG packetizer.
// No dependencies; every other file except rjp_ifs imports this package.
`default_nettype none
package rjp_pkg;

    localparam int MAX_FRAG          = 1100;
    localparam int QUANT_TABLE_BYTES = 64;
    localparam int QUANT_TOTAL       = 2 * QUANT_TABLE_BYTES;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0] RTP_PT_JPEG      = 8'h1a;
    localparam logic [7:0] Q_DEFAULT        = 8'h5e;
    localparam logic [7:0] Q_TABLES         = 8'd128;
    localparam logic [7:0] DOLLAR           = 8'h24;
    localparam logic [31:0] SSRC            = 32'h13f97e67;

    localparam logic [16:0] TICKS_PER_SEC   = 17'd90000;
    localparam logic [31:0] DELTA_WRAP_MS   = 32'd1000;
    // Reciprocal of 1000 scaled by 2^38, exact for every 32-bit dividend.
    localparam logic [28:0] RECIP_1000      = 29'd274877907;
    localparam int          RECIP_SHIFT     = 38;

    // Header byte positions.
    localparam logic [4:0] POS_RTP      = 5'd4;
    localparam logic [4:0] POS_END_BASE = 5'd24;
    localparam logic [4:0] POS_END_QT   = 5'd28;

    typedef enum logic [1:0] {
        OP_FRAME   = 2'd0,
        OP_QUANT   = 2'd1,
        OP_PAYLOAD = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        FR_IDLE  = 2'd0,
        FR_MUL   = 2'd1,
        FR_RECIP = 2'd2
    } front_state_t;

    typedef enum logic [1:0] {
        REG_WIDTH   = 2'd0,
        REG_HEIGHT  = 2'd1,
        REG_PREFIX  = 2'd2,
        REG_ENABLE  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [10:0] image_width;
        logic [10:0] image_height;
        logic        interleaved_prefix;
        logic        stream_enabled;
    } cfg_t;

    // One queue entry: an optional fragment header followed by one byte.
    typedef struct packed {
        logic        hdr;
        logic        tables;
        logic        last;
        logic        end_pkt;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [23:0] offset;
        logic [10:0] size;
        logic [7:0]  data;
    } qent_t;

endpackage
`default_nettype wire

[design/rjp_ifs.sv]
// Stream channel interfaces of the RTP/JPEG packetizer.
// Depends on nothing; ports carry valid, ready and the payload fields.
`default_nettype none
interface rjp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic [23:0] frame_len;
    logic [31:0] time_ms;
    logic        has_quant;
    modport source (output valid, op, data_byte, frame_len, time_ms, has_quant, input ready);
    modport sink   (input valid, op, data_byte, frame_len, time_ms, has_quant, output ready);
endinterface

interface rjp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_end;
    modport source (output valid, out_byte, packet_end, input ready);
    modport sink   (input valid, out_byte, packet_end, output ready);
endinterface
`default_nettype wire

[design/rjp_front.sv]
// Front end: accepts input items, keeps frame and RTP state, and queues jobs.
// Depends on rjp_pkg.
`default_nettype none
module rjp_front
    import rjp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  data_byte,
    input  wire logic [23:0] frame_len,
    input  wire logic [31:0] time_ms,
    input  wire logic        has_quant,
    input  wire logic  q_full,
    output logic       q_push,
    output qent_t      q_data
);

    front_state_t state_reg, state_next;
    logic [15:0] seq_reg, seq_next;
    logic [31:0] ts_reg, ts_next;
    logic [31:0] prev_ms_reg, prev_ms_next;
    logic [31:0] delta_reg, delta_next;
    logic [23:0] len_reg, len_next;
    logic [23:0] off_reg, off_next;
    logic [10:0] frem_reg, frem_next;
    logic        qp_reg, qp_next;
    logic [7:0]  qc_reg, qc_next;
    logic [31:0] dms_reg, dms_next;
    logic [31:0] mul_reg;

    logic        accept;
    logic [23:0] left;
    logic [10:0] flen;
    logic        last_frag;
    logic [31:0] base_ms;
    logic [60:0] recip_prod;
    logic [48:0] mul_prod;

    assign accept    = in_valid && in_ready;
    assign left      = len_reg - off_reg;
    assign last_frag = (left <= 24'(MAX_FRAG));
    assign flen      = last_frag ? left[10:0] : 11'(MAX_FRAG);
    assign base_ms   = (prev_ms_reg == 32'd0) ? time_ms : prev_ms_reg;
    assign mul_prod  = 49'(dms_reg) * 49'(TICKS_PER_SEC);
    assign recip_prod = 61'(mul_reg) * 61'(RECIP_1000);

    // Next-state logic of the timestamp delta sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE:  if (accept && op == OP_FRAME) state_next = FR_MUL;
            FR_MUL:   state_next = FR_RECIP;
            FR_RECIP: state_next = FR_IDLE;
            default:  state_next = FR_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == FR_IDLE) && !q_full;
    end

    always_comb
    begin
        seq_next     = seq_reg;
        ts_next      = ts_reg;
        prev_ms_next = prev_ms_reg;
        delta_next   = delta_reg;
        len_next     = len_reg;
        off_next     = off_reg;
        frem_next    = frem_reg;
        qp_next      = qp_reg;
        qc_next      = qc_reg;
        dms_next     = dms_reg;
        q_push       = 1'b0;
        q_data.hdr     = 1'b0;
        q_data.tables  = 1'b0;
        q_data.last    = last_frag;
        q_data.end_pkt = 1'b0;
        q_data.seq     = seq_reg;
        q_data.ts      = ts_reg;
        q_data.offset  = off_reg;
        q_data.size    = 11'd0;
        q_data.data    = data_byte;

        if (state_reg == FR_RECIP)
        begin
            delta_next = 32'(recip_prod[60:RECIP_SHIFT]);
        end

        if (accept)
        begin
            unique case (op)
                OP_FRAME:
                begin
                    ts_next      = ts_reg + delta_reg;
                    dms_next     = (time_ms >= base_ms) ? (time_ms - base_ms) : DELTA_WRAP_MS;
                    prev_ms_next = time_ms;
                    len_next     = frame_len;
                    off_next     = 24'd0;
                    frem_next    = 11'd0;
                    qp_next      = has_quant;
                    qc_next      = 8'd0;
                end
                OP_QUANT:
                begin
                    if (cfg.stream_enabled && qp_reg && off_reg == 24'd0 && len_reg != 24'd0
                        && !(qc_reg == 8'd0 && frem_reg != 11'd0))
                    begin
                        q_push = 1'b1;
                        if (qc_reg == 8'd0)
                        begin
                            q_data.hdr    = 1'b1;
                            q_data.tables = 1'b1;
                            q_data.size   = flen + 11'(20 + 4 + QUANT_TOTAL);
                            seq_next      = seq_reg + 16'd1;
                            frem_next     = flen;
                        end
                        qc_next = qc_reg + 8'd1;
                        if (qc_next >= 8'(QUANT_TOTAL))
                        begin
                            qp_next = 1'b0;
                        end
                    end
                end
                OP_PAYLOAD:
                begin
                    if (cfg.stream_enabled && !(qp_reg && qc_reg != 8'd0) && off_reg < len_reg)
                    begin
                        q_push = 1'b1;
                        if (frem_reg == 11'd0)
                        begin
                            qp_next      = 1'b0;
                            q_data.hdr   = 1'b1;
                            q_data.size  = flen + 11'd20;
                            seq_next     = seq_reg + 16'd1;
                            frem_next    = flen - 11'd1;
                        end
                        else
                        begin
                            frem_next = frem_reg - 11'd1;
                        end
                        off_next       = off_reg + 24'd1;
                        q_data.end_pkt = (frem_next == 11'd0);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= FR_IDLE;
            seq_reg     <= '0;
            ts_reg      <= '0;
            prev_ms_reg <= '0;
            delta_reg   <= '0;
            len_reg     <= '0;
            off_reg     <= '0;
            frem_reg    <= '0;
            qp_reg      <= 1'b0;
            qc_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            seq_reg     <= seq_next;
            ts_reg      <= ts_next;
            prev_ms_reg <= prev_ms_next;
            delta_reg   <= delta_next;
            len_reg     <= len_next;
            off_reg     <= off_next;
            frem_reg    <= frem_next;
            qp_reg      <= qp_next;
            qc_reg      <= qc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dms_reg <= dms_next;
        if (state_reg == FR_MUL)
        begin
            mul_reg <= mul_prod[31:0];
        end
    end

endmodule
`default_nettype wire

[design/rjp_queue.sv]
// Short job queue between the front end and the byte serializer.
// Depends on rjp_pkg for the entry type and depth.
`default_nettype none
module rjp_queue
    import rjp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire qent_t push_data,
    output logic       full,
    input  wire logic  pop,
    output logic       head_valid,
    output qent_t      head
);

    qent_t mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

[design/rjp_back.sv]
// Back end: expands each queued job into header bytes and its data byte.
// Depends on rjp_pkg; drives the registered output channel.
`default_nettype none
module rjp_back
    import rjp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  head_valid,
    input  wire qent_t head,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [7:0] out_byte,
    output logic       packet_end
);

    logic [4:0] pos_reg, pos_next;
    logic [4:0] idx;
    logic [4:0] hdr_end;
    logic       is_data;
    logic       load;
    logic [7:0] byte_sel;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       end_reg;

    assign idx     = (pos_reg < POS_RTP && !cfg.interleaved_prefix) ? POS_RTP : pos_reg;
    assign hdr_end = head.tables ? POS_END_QT : POS_END_BASE;
    assign is_data = !head.hdr || (idx == hdr_end);
    assign load    = head_valid && (!valid_reg || out_ready);
    assign pop     = load && is_data;

    always_comb
    begin
        pos_next = pos_reg;
        if (load)
        begin
            pos_next = is_data ? 5'd0 : idx + 5'd1;
        end
    end

    always_comb
    begin
        byte_sel = 8'd0;
        if (is_data)
        begin
            byte_sel = head.data;
        end
        else
        begin
            unique case (idx)
                5'd0:  byte_sel = DOLLAR;
                5'd2:  byte_sel = {5'd0, head.size[10:8]};
                5'd3:  byte_sel = head.size[7:0];
                5'd4:  byte_sel = RTP_VERSION_BYTE;
                5'd5:  byte_sel = RTP_PT_JPEG | {head.last, 7'd0};
                5'd6:  byte_sel = head.seq[15:8];
                5'd7:  byte_sel = head.seq[7:0];
                5'd8:  byte_sel = head.ts[31:24];
                5'd9:  byte_sel = head.ts[23:16];
                5'd10: byte_sel = head.ts[15:8];
                5'd11: byte_sel = head.ts[7:0];
                5'd12: byte_sel = SSRC[31:24];
                5'd13: byte_sel = SSRC[23:16];
                5'd14: byte_sel = SSRC[15:8];
                5'd15: byte_sel = SSRC[7:0];
                5'd17: byte_sel = head.offset[23:16];
                5'd18: byte_sel = head.offset[15:8];
                5'd19: byte_sel = head.offset[7:0];
                5'd21: byte_sel = head.tables ? Q_TABLES : Q_DEFAULT;
                5'd22: byte_sel = cfg.image_width[10:3];
                5'd23: byte_sel = cfg.image_height[10:3];
                5'd27: byte_sel = 8'(QUANT_TOTAL);
                default: byte_sel = 8'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_sel;
            end_reg  <= is_data && head.end_pkt;
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign packet_end = end_reg;

endmodule
`default_nettype wire

[design/rtp_jpeg_packetizer_top.sv]
// RTP/JPEG packetizer top level: configuration registers, front, queue, back.
// Depends on rjp_pkg, rjp_ifs, rjp_front, rjp_queue and rjp_back.
//
// Items enter on in_ch: frame starts (op 0), quantization table bytes (op 1)
// and scan payload bytes (op 2). Packet bytes leave on out_ch one per
// transfer, with packet_end set on the last byte of each packet.
// Configuration is written through cfg_wen/cfg_index/cfg_data; the user must
// do so only while idle; the block does not enforce this. An accepted table
// or payload byte goes through the job queue into the output register and is
// held there until the receiver is ready. A byte that opens a fragment first
// emits 20 to 28 header bytes, so the sustained rate is one output byte per
// cycle while the receiver is ready, set by the single-byte output register;
// input is taken every cycle while the four-entry job queue has room. A frame
// start takes the front end through FR_MUL and FR_RECIP, the two registered
// multiplies that turn the millisecond delta into 90 kHz ticks. Reset zeroes
// the configuration and all frame and RTP state but the multiplier registers
// dms_reg and mul_reg. When the receiver stalls, the output register holds
// its byte, the queue fills, and then in_ch.ready drops until room frees up.
`default_nettype none
module rtp_jpeg_packetizer_top
    import rjp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    rjp_in_if.sink           in_ch,
    rjp_out_if.source        out_ch,
    input  wire logic        cfg_wen,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);

    cfg_t  cfg_reg;
    logic  q_push, q_full, q_pop, q_head_valid;
    qent_t q_in, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_WIDTH:  cfg_reg.image_width        <= cfg_data;
                REG_HEIGHT: cfg_reg.image_height       <= cfg_data;
                REG_PREFIX: cfg_reg.interleaved_prefix <= cfg_data[0];
                REG_ENABLE: cfg_reg.stream_enabled     <= cfg_data[0];
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    rjp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .op        (in_ch.op),
        .data_byte (in_ch.data_byte),
        .frame_len (in_ch.frame_len),
        .time_ms   (in_ch.time_ms),
        .has_quant (in_ch.has_quant),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    rjp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    rjp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_byte   (out_ch.out_byte),
        .packet_end (out_ch.packet_end)
    );

endmodule
`default_nettype wire

[verif/rtp_jpeg_packetizer_top_test.sv]
// Self-checking testbench for the RTP/JPEG packetizer top level.
// Depends on rjp_pkg, rjp_ifs and rtp_jpeg_packetizer_top; a directed table
// runs first, then random frames are checked against a packet-byte predictor.
`default_nettype none
module rtp_jpeg_packetizer_top_test;
    import rjp_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASE_ITEMS [5] = '{150, 20, 80, 60, 50};

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  data_byte;
        logic [23:0] frame_len;
        logic [31:0] time_ms;
        logic        has_quant;
        int          n_bytes;   // -1: left to the predictor alone
    } stim_row_t;

    typedef struct {
        logic [7:0] pkt_byte;
        logic       pkt_end;
    } pkt_byte_t;

    logic clk;
    logic rst_n;
    logic cfg_wen;
    logic [1:0] cfg_index;
    logic [10:0] cfg_data;

    rjp_in_if  in_ch ();
    rjp_out_if out_ch ();

    rtp_jpeg_packetizer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of configuration and stream state.
    logic [10:0] img_w, img_h;
    logic        use_prefix, enabled;
    logic [15:0] seq_no;
    logic [31:0] rtp_ts, last_ms, ts_step;
    logic [23:0] frm_len, frm_off;
    logic [10:0] frag_left;
    logic        tables_due;
    logic [7:0]  tables_seen;

    pkt_byte_t packet_bytes_q[$];
    int errors;
    int items;
    int target;
    int cycles;
    bit quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report(input string what);
        errors++;
        if (errors <= 40)
            $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    function automatic void emit(input logic [7:0] b, input logic e);
        pkt_byte_t p;
        p.pkt_byte = b;
        p.pkt_end = e;
        packet_bytes_q.push_back(p);
    endfunction

    function automatic void emit_header(input bit with_tables);
        logic [23:0] left;
        logic [10:0] flen;
        logic [15:0] size;
        bit last;
        left = frm_len - frm_off;
        flen = (left < MAX_FRAG) ? left[10:0] : 11'(MAX_FRAG);
        last = (frm_off + 24'(flen)) == frm_len;
        size = 16'(flen) + 16'd20 + (with_tables ? 16'(4 + QUANT_TOTAL) : 16'd0);
        if (use_prefix)
        begin
            emit(DOLLAR, 0); emit(8'd0, 0); emit(size[15:8], 0); emit(size[7:0], 0);
        end
        emit(RTP_VERSION_BYTE, 0);
        emit(RTP_PT_JPEG | (last ? 8'h80 : 8'h00), 0);
        emit(seq_no[15:8], 0); emit(seq_no[7:0], 0);
        emit(rtp_ts[31:24], 0); emit(rtp_ts[23:16], 0);
        emit(rtp_ts[15:8], 0); emit(rtp_ts[7:0], 0);
        emit(SSRC[31:24], 0); emit(SSRC[23:16], 0); emit(SSRC[15:8], 0); emit(SSRC[7:0], 0);
        emit(8'd0, 0);
        emit(frm_off[23:16], 0); emit(frm_off[15:8], 0); emit(frm_off[7:0], 0);
        emit(8'd0, 0);
        emit(with_tables ? Q_TABLES : Q_DEFAULT, 0);
        emit(8'(img_w / 8), 0); emit(8'(img_h / 8), 0);
        if (with_tables)
        begin
            emit(8'd0, 0); emit(8'd0, 0); emit(8'd0, 0); emit(8'(QUANT_TOTAL), 0);
        end
        seq_no = seq_no + 16'd1;
        frag_left = flen;
    endfunction

    // Appends the packet bytes caused by one accepted item; returns their count.
    function automatic int predict_packet_bytes(input stim_row_t it);
        int start_count;
        logic [31:0] dms, prod;
        start_count = packet_bytes_q.size();
        case (it.op)
            OP_FRAME:
            begin
                rtp_ts = rtp_ts + ts_step;
                if (last_ms == 32'd0)
                    last_ms = it.time_ms;
                dms = (it.time_ms >= last_ms) ? it.time_ms - last_ms : DELTA_WRAP_MS;
                last_ms = it.time_ms;
                prod = 32'd90000 * dms;
                ts_step = prod / 32'd1000;
                frm_len = it.frame_len;
                frm_off = '0;
                frag_left = '0;
                tables_due = it.has_quant;
                tables_seen = '0;
            end
            OP_QUANT:
            begin
                if (enabled && tables_due && frm_off == 0 && frm_len != 0
                    && !(tables_seen == 0 && frag_left != 0))
                begin
                    if (tables_seen == 0)
                        emit_header(1);
                    emit(it.data_byte, 0);
                    tables_seen = tables_seen + 8'd1;
                    if (tables_seen >= QUANT_TOTAL)
                        tables_due = 1'b0;
                end
            end
            OP_PAYLOAD:
            begin
                if (enabled && !(tables_due && tables_seen > 0) && frm_off < frm_len)
                begin
                    if (frag_left == 0)
                    begin
                        tables_due = 1'b0;
                        emit_header(0);
                    end
                    frag_left = frag_left - 11'd1;
                    frm_off = frm_off + 24'd1;
                    emit(it.data_byte, frag_left == 0);
                end
            end
            default: ;
        endcase
        return packet_bytes_q.size() - start_count;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input stim_row_t it);
        int gap;
        int n;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= it.op;
        in_ch.data_byte <= it.data_byte;
        in_ch.frame_len <= it.frame_len;
        in_ch.time_ms   <= it.time_ms;
        in_ch.has_quant <= it.has_quant;
        do
            @(posedge clk);
        while (!in_ch.ready);
        n = predict_packet_bytes(it);
        if (it.n_bytes >= 0 && n != it.n_bytes)
            report($sformatf("item op %0d caused %0d bytes, table says %0d",
                             it.op, n, it.n_bytes));
        items++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (packet_bytes_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [10:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        case (idx)
            REG_WIDTH:  img_w = val;
            REG_HEIGHT: img_h = val;
            REG_PREFIX: use_prefix = val[0];
            default:    enabled = val[0];
        endcase
    endtask

    task automatic configure(input logic [10:0] w, input logic [10:0] h,
                             input logic p, input logic en);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_PREFIX, {10'd0, p});
        write_reg(REG_ENABLE, {10'd0, en});
    endtask

    function automatic stim_row_t mk(input logic [1:0] op, input logic [7:0] b);
        stim_row_t it;
        it.op = op;
        it.data_byte = b;
        it.frame_len = 24'($urandom);
        it.time_ms = $urandom;
        it.has_quant = 1'($urandom);
        it.n_bytes = -1;
        return it;
    endfunction

    // One random frame: mostly well formed, some broken, some with noise.
    // The frame is cut short once the phase has used up its items.
    task automatic random_frame();
        stim_row_t it;
        int kind, n_tab, n_pay;
        kind = $urandom_range(0, 9);
        it = mk(OP_FRAME, 8'($urandom));
        it.frame_len = ($urandom_range(0, 14) == 0) ? 24'($urandom_range(1095, 1250))
                                                    : 24'($urandom_range(1, 40));
        case ($urandom_range(0, 5))
            0:       it.time_ms = $urandom;
            1:       it.time_ms = last_ms - 32'($urandom_range(1, 50));
            default: it.time_ms = last_ms + 32'($urandom_range(0, 120));
        endcase
        send_item(it);
        n_tab = it.has_quant ? ((kind == 0) ? $urandom_range(1, 127) : QUANT_TOTAL) : 0;
        if (kind == 1)
            n_tab = $urandom_range(0, 3);
        n_pay = int'(it.frame_len) + ((kind == 2) ? $urandom_range(1, 4) : 0);
        if (kind == 0 && $urandom_range(0, 1) == 1)
            n_pay = $urandom_range(0, n_pay);
        for (int i = 0; i < n_tab && items < target; i++)
            send_item(mk(OP_QUANT, 8'($urandom)));
        for (int i = 0; i < n_pay && items < target; i++)
        begin
            if (kind == 3 && $urandom_range(0, 9) == 0)
                send_item(mk(($urandom_range(0, 1) == 1) ? OP_NONE : OP_QUANT, 8'($urandom)));
            send_item(mk(OP_PAYLOAD, 8'($urandom)));
        end
    endtask

    stim_row_t directed[] = '{
        '{OP_FRAME,   8'h00, 24'd1,        32'd0,          1'b0, 0},
        '{OP_PAYLOAD, 8'hff, 24'd0,        32'd0,          1'b0, 25},
        '{OP_PAYLOAD, 8'h00, 24'hffffff,   32'hffffffff,   1'b1, 0},
        '{OP_NONE,    8'hff, 24'hffffff,   32'hffffffff,   1'b1, 0},
        '{OP_QUANT,   8'h5a, 24'd0,        32'd0,          1'b0, 0},
        '{OP_FRAME,   8'h00, 24'd2,        32'hffffffff,   1'b1, 0},
        '{OP_QUANT,   8'h55, 24'd0,        32'd0,          1'b0, 29},
        '{OP_QUANT,   8'haa, 24'd0,        32'd0,          1'b0, 1},
        '{OP_PAYLOAD, 8'h11, 24'd0,        32'd0,          1'b0, 0},
        '{OP_FRAME,   8'h00, 24'd3,        32'd5,          1'b1, 0},
        '{OP_PAYLOAD, 8'h12, 24'd0,        32'd0,          1'b0, 25},
        '{OP_QUANT,   8'h34, 24'd0,        32'd0,          1'b0, 0},
        '{OP_PAYLOAD, 8'h56, 24'd0,        32'd0,          1'b0, 1},
        '{OP_PAYLOAD, 8'h78, 24'd0,        32'd0,          1'b0, 1},
        '{OP_FRAME,   8'h00, 24'hffffff,   32'd100,        1'b0, 0},
        '{OP_PAYLOAD, 8'h9a, 24'd0,        32'd0,          1'b0, 25},
        '{OP_PAYLOAD, 8'hbc, 24'd0,        32'd0,          1'b0, 1},
        '{OP_FRAME,   8'h00, 24'd1,        32'd0,          1'b0, 0},
        '{OP_PAYLOAD, 8'hde, 24'd0,        32'd0,          1'b0, -1}
    };

    // Result checker: every transfer is compared with the oldest expected byte.
    always @(posedge clk)
    begin
        pkt_byte_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (packet_bytes_q.size() == 0)
                report($sformatf("unexpected byte %02h", out_ch.out_byte));
            else
            begin
                e = packet_bytes_q.pop_front();
                if (out_ch.out_byte !== e.pkt_byte)
                    report($sformatf("out_byte %02h, expected %02h",
                                     out_ch.out_byte, e.pkt_byte));
                if (out_ch.packet_end !== e.pkt_end)
                    report($sformatf("packet_end %0b, expected %0b",
                                     out_ch.packet_end, e.pkt_end));
            end
        end
    end

    // Receiver stalls: mostly short, a few long, none while quiet.
    int stall_left;
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(0, 2);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = '0;
        in_ch.data_byte = '0;
        in_ch.frame_len = '0;
        in_ch.time_ms = '0;
        in_ch.has_quant = 1'b0;
        out_ch.ready = 1'b0;
        stall_left = 0;
        errors = 0;
        items = 0;
        target = 0;
        cycles = 0;
        quiet = 1'b0;
        img_w = '0; img_h = '0; use_prefix = 1'b0; enabled = 1'b0;
        seq_no = '0; rtp_ts = '0; last_ms = '0; ts_step = '0;
        frm_len = '0; frm_off = '0; frag_left = '0;
        tables_due = 1'b0; tables_seen = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(11'd2047, 11'd2047, 1'b1, 1'b1);
        foreach (directed[i])
            send_item(directed[i]);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: configure(11'd0, 11'd0, 1'b0, 1'b1);
                1: configure(11'($urandom), 11'($urandom), 1'b1, 1'b0);
                2: configure(11'($urandom), 11'($urandom), 1'b1, 1'b1);
                default: configure(11'($urandom), 11'($urandom), 1'($urandom), 1'b1);
            endcase
            quiet = (ph == 3);
            target = items + PHASE_ITEMS[ph];
            while (items < target)
                random_frame();
            // Sender holds off here until every expected byte has arrived.
            drain();
        end

        quiet = 1'b0;
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire

[filelist.f]
design/rjp_pkg.sv
design/rjp_ifs.sv
design/rjp_front.sv
design/rjp_queue.sv
design/rjp_back.sv
design/rtp_jpeg_packetizer_top.sv
verif/rtp_jpeg_packetizer_top_test.sv
